### rtl/ffra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types and constants of the first-fit region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int ADDR_W = 48;          // byte address and length width
	localparam int REQ_W  = 32;          // request size width
	localparam int SIZE_W = REQ_W + 1;   // page-rounded size, may reach 2^32
	localparam int SUM_W  = ADDR_W + 2;  // candidate address plus size
	localparam int CFG_IDX_W = 2;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SIZE   = 3'd1,
		ST_NO_ROOM    = 3'd2,
		ST_FULL       = 3'd3,
		ST_NULL       = 3'd4,
		ST_MISALIGNED = 3'd5,
		ST_NOT_FOUND  = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_BASE = 2'd0,
		CFG_WINDOW_END  = 2'd1,
		CFG_MAX_REQUEST = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_SHIFT,
		S_REMOVE,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] free_address;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] region_address;
		status_t           status;
	} out_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] window_base;
		logic [ADDR_W-1:0] window_end;
		logic [ADDR_W-1:0] max_request;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} entry_t;

	localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 48'h0;
	localparam logic [ADDR_W-1:0] WINDOW_END_RST  = 48'h0000_4000_0000;
	localparam logic [ADDR_W-1:0] MAX_REQUEST_RST = 48'h0000_4000_0000;

endpackage
`default_nettype wire

### rtl/ffra_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_in_if
// request channel: valid/ready handshake carrying one request word
// ----------------------------------------------------------------------------
interface ffra_in_if;
	import ffra_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/ffra_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_out_if
// response channel: valid/ready handshake carrying one response word
// ----------------------------------------------------------------------------
interface ffra_out_if;
	import ffra_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/ffra_region_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_region_mem
// region table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module ffra_region_mem #(
	parameter int DEPTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire ffra_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output ffra_pkg::entry_t     rdata
);
	import ffra_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/ffra_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_seq
// request sequencer: streams the region table through the read port for the
// first-fit or exact-match scan, then shifts entries to insert or remove
// ----------------------------------------------------------------------------
module ffra_seq #(
	parameter int MAX_REGIONS = 32,
	parameter int PAGE_BYTES  = 4096,
	localparam int IDX_W      = $clog2(MAX_REGIONS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ffra_in_if.sink                req,
	input  wire ffra_pkg::cfg_t    cfg,
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output ffra_pkg::entry_t       mem_wdata,
	output logic [IDX_W-1:0]       mem_raddr,
	input  wire ffra_pkg::entry_t  mem_rdata,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output ffra_pkg::out_word_t    res
);
	import ffra_pkg::*;

	localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);   // page size is a power of two
	localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_REGIONS);

	seq_state_t          state_q, state_d;
	kind_t               kind_q, kind_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [ADDR_W-1:0]   faddr_q, faddr_d;
	logic [ADDR_W:0]     addr_q, addr_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic [CNT_W-1:0]    k_q, k_d;
	logic [CNT_W-1:0]    count_q, count_d;
	out_word_t           res_q, res_d;

	logic [SIZE_W-1:0]   size_sum;
	logic [SIZE_W-1:0]   size_c;
	logic [SUM_W-1:0]    fit_sum;
	logic [CNT_W-1:0]    raddr_c;

	// page rounding of the incoming request
	assign size_sum = {1'b0, req.payload.request_bytes} + PAGE_MASK;
	assign size_c   = size_sum & ~PAGE_MASK;

	// candidate end for the current gap
	assign fit_sum = SUM_W'(size_q) + SUM_W'(addr_q);

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;
	assign mem_raddr = raddr_c[IDX_W-1:0];

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		size_d    = size_q;
		faddr_d   = faddr_q;
		addr_d    = addr_q;
		idx_d     = idx_q;
		k_d       = k_q;
		count_d   = count_q;
		res_d     = res_q;
		raddr_c   = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = mem_rdata;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					kind_d  = req.payload.kind;
					size_d  = size_c;
					faddr_d = req.payload.free_address;
					addr_d  = (ADDR_W + 1)'(cfg.window_base);
					idx_d   = '0;
					res_d   = '{region_address: '0, status: ST_OK};
					if (req.payload.kind == KIND_ALLOC) begin
						if (size_c == '0 || ADDR_W'(size_c) > cfg.max_request) begin
							res_d.status = ST_BAD_SIZE;
							state_d      = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						if (req.payload.free_address == '0) begin
							res_d.status = ST_NULL;
							state_d      = S_RESP;
						end else if (req.payload.free_address[PAGE_SHIFT-1:0] != '0) begin
							res_d.status = ST_MISALIGNED;
							state_d      = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end
				end
			end

			S_SCAN: begin
				// read data holds entry idx_q, next entry requested speculatively
				raddr_c = CNT_W'(idx_q + CNT_W'(1));
				if (kind_q == KIND_ALLOC) begin
					if (idx_q == count_q || fit_sum < SUM_W'(mem_rdata.start)) begin
						state_d = S_PLACE;
					end else begin
						addr_d = (ADDR_W + 1)'(mem_rdata.start) + (ADDR_W + 1)'(mem_rdata.length);
						idx_d  = CNT_W'(idx_q + CNT_W'(1));
					end
				end else begin
					if (idx_q == count_q) begin
						res_d.status = ST_NOT_FOUND;
						state_d      = S_RESP;
					end else if (mem_rdata.start == faddr_q) begin
						state_d = S_REMOVE;
					end else begin
						idx_d = CNT_W'(idx_q + CNT_W'(1));
					end
				end
			end

			S_PLACE: begin
				raddr_c = CNT_W'(count_q - CNT_W'(1));
				k_d     = count_q;
				if (fit_sum >= SUM_W'(cfg.window_end)) begin
					res_d.status = ST_NO_ROOM;
					state_d      = S_RESP;
				end else if (count_q >= CNT_MAX) begin
					res_d.status = ST_FULL;
					state_d      = S_RESP;
				end else begin
					state_d = S_SHIFT;
				end
			end

			S_SHIFT: begin
				// read data holds entry k_q-1, moved up to k_q
				raddr_c = CNT_W'(k_q - CNT_W'(2));
				mem_we  = 1'b1;
				if (k_q == idx_q) begin
					mem_waddr       = idx_q[IDX_W-1:0];
					mem_wdata.start  = addr_q[ADDR_W-1:0];
					mem_wdata.length = ADDR_W'(size_q) + ADDR_W'(PAGE_BYTES);
					count_d          = CNT_W'(count_q + CNT_W'(1));
					res_d.region_address = addr_q[ADDR_W-1:0];
					res_d.status     = ST_OK;
					state_d          = S_RESP;
				end else begin
					mem_waddr = k_q[IDX_W-1:0];
					k_d       = CNT_W'(k_q - CNT_W'(1));
				end
			end

			S_REMOVE: begin
				// read data holds entry idx_q+1, moved down to idx_q
				raddr_c = CNT_W'(idx_q + CNT_W'(2));
				if (CNT_W'(idx_q + CNT_W'(1)) == count_q) begin
					count_d      = CNT_W'(count_q - CNT_W'(1));
					res_d.status = ST_OK;
					state_d      = S_RESP;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[IDX_W-1:0];
					idx_d     = CNT_W'(idx_q + CNT_W'(1));
				end
			end

			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		size_q  <= size_d;
		faddr_q <= faddr_d;
		addr_q  <= addr_d;
		idx_q   <= idx_d;
		k_q     <= k_d;
		res_q   <= res_d;
	end

`ifndef SYNTHESIS
	// table never holds more regions than it has entries
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_MAX)
		else $error("region count above table depth");

	// table is written only while shifting entries
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SHIFT || state_q == S_REMOVE))
		else $error("table write outside shift");

	// insert shift never walks below the insert position
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (k_q >= idx_q && k_q <= count_q))
		else $error("insert shift out of range");

	// remove shift stays inside the valid entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REMOVE) |-> (idx_q < count_q))
		else $error("remove shift out of range");

	// a completed insert adds exactly one region
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && k_q == idx_q) |=> (count_q == CNT_W'($past(count_q) + 1)))
		else $error("insert did not bump region count");
`endif

endmodule
`default_nettype wire

### rtl/first_fit_region_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// first-fit allocator of page-rounded regions inside an address window
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req       in   valid/ready    kind, request_bytes, free_address
//  rsp       out  valid/ready    region_address, status
//  cfg       in   cfg_we only    cfg_index, cfg_data
//
//  one read per cycle streams the table through the memory read port for
//  the scan, then one entry per cycle moves on insert or remove
//  rejections decided from the request alone skip the scan
//  reset clears the region count and presets config, table needs no sweep
//  a new request is taken while the previous response waits in rsp
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
	parameter int MAX_REGIONS = 32,
	parameter int PAGE_BYTES  = 4096     // power of two
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ffra_in_if.sink                            req,
	ffra_out_if.source                         rsp,
	input  wire logic                          cfg_we,
	input  wire logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ffra_pkg::ADDR_W-1:0]   cfg_data
);
	import ffra_pkg::*;

	localparam int IDX_W = $clog2(MAX_REGIONS);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_base <= WINDOW_BASE_RST;
			cfg_q.window_end  <= WINDOW_END_RST;
			cfg_q.max_request <= MAX_REQUEST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_BASE: cfg_q.window_base <= cfg_data;
				CFG_WINDOW_END:  cfg_q.window_end  <= cfg_data;
				CFG_MAX_REQUEST: cfg_q.max_request <= cfg_data;
				default: ;   // unused index, write dropped
			endcase
		end
	end

	// region table memory
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_wdata;
	entry_t           mem_rdata;

	ffra_region_mem #(
		.DEPTH (MAX_REGIONS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer: scan, insert and remove
	logic      res_valid;
	logic      res_ready;
	out_word_t res;

	ffra_seq #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// response word register, loads when empty or being drained
	logic      out_valid_q;
	out_word_t out_word_q;

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_word_q <= res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_word_q;

endmodule
`default_nettype wire

### dv/first_fit_region_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_checker
// watches request, response and register ports, keeps its own region table
// and window registers, compares each response word with the oldest reply owed
// ----------------------------------------------------------------------------
module first_fit_region_allocator_checker
	import ffra_pkg::*;
#(
	parameter int MAX_REGIONS = 32,
	parameter int PAGE_BYTES  = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ffra_in_if                        req,
	ffra_out_if                       rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	output int unsigned               mismatch_count,
	output int unsigned               replies_owed
);

	localparam logic [63:0] PAGE64  = 64'(PAGE_BYTES);
	localparam logic [63:0] LIMIT48 = 64'h0000_FFFF_FFFF_FFFF;

	logic [ADDR_W-1:0] tbl_start [MAX_REGIONS];
	logic [ADDR_W-1:0] tbl_len   [MAX_REGIONS];
	int unsigned       tbl_count;
	logic [ADDR_W-1:0] win_base;
	logic [ADDR_W-1:0] win_end;
	logic [ADDR_W-1:0] size_limit;
	out_word_t         owed_replies [$];

	// updates the table as the block would and returns its reply
	function automatic out_word_t predict_region_reply(in_word_t w);
		out_word_t   r;
		logic [63:0] size;
		logic [63:0] addr;
		logic [63:0] len;
		int unsigned pos;
		int unsigned i;
		int unsigned k;
		bit          hit;
		r.region_address = '0;
		r.status         = ST_OK;
		if (w.kind == KIND_ALLOC) begin
			size = ((64'(w.request_bytes) + PAGE64 - 64'd1) / PAGE64) * PAGE64;
			if (size == 64'd0 || size > 64'(size_limit)) begin
				r.status = ST_BAD_SIZE;
				return r;
			end
			addr = 64'(win_base);
			pos  = 0;
			// a gap fits only if the end lies strictly below the next start
			while (pos < tbl_count && size + addr >= 64'(tbl_start[pos])) begin
				addr = 64'(tbl_start[pos]) + 64'(tbl_len[pos]);
				pos++;
			end
			if (addr + size >= 64'(win_end)) begin
				r.status = ST_NO_ROOM;
			end else if (tbl_count >= MAX_REGIONS) begin
				r.status = ST_FULL;
			end else begin
				for (i = tbl_count; i > pos; i--) begin
					tbl_start[i] = tbl_start[i-1];
					tbl_len[i]   = tbl_len[i-1];
				end
				len = size + PAGE64;
				if (len > LIMIT48) len = LIMIT48;
				tbl_start[pos]   = addr[ADDR_W-1:0];
				tbl_len[pos]     = len[ADDR_W-1:0];
				tbl_count++;
				r.region_address = addr[ADDR_W-1:0];
			end
		end else begin
			if (w.free_address == '0) begin
				r.status = ST_NULL;
			end else if (64'(w.free_address) % PAGE64 != 64'd0) begin
				r.status = ST_MISALIGNED;
			end else begin
				r.status = ST_NOT_FOUND;
				hit      = 1'b0;
				for (i = 0; i < tbl_count && !hit; i++) begin
					if (tbl_start[i] == w.free_address) begin
						hit = 1'b1;
						for (k = i; k + 1 < tbl_count; k++) begin
							tbl_start[k] = tbl_start[k+1];
							tbl_len[k]   = tbl_len[k+1];
						end
						tbl_count--;
						r.status = ST_OK;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_ports
		out_word_t oldest;
		if (!arst_n) begin
			tbl_count      = 0;
			win_base       = WINDOW_BASE_RST;
			win_end        = WINDOW_END_RST;
			size_limit     = MAX_REQUEST_RST;
			mismatch_count = 0;
			owed_replies.delete();
			for (int i = 0; i < MAX_REGIONS; i++) begin
				tbl_start[i] = '0;
				tbl_len[i]   = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_BASE: win_base   = cfg_data;
					CFG_WINDOW_END:  win_end    = cfg_data;
					CFG_MAX_REQUEST: size_limit = cfg_data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					mismatch_count++;
					$error("response word with no request outstanding: addr %h status %0d",
						rsp.payload.region_address, rsp.payload.status);
				end else begin
					oldest = owed_replies.pop_front();
					if (rsp.payload.region_address !== oldest.region_address) begin
						$error("region_address: expected %h, got %h",
							oldest.region_address, rsp.payload.region_address);
						mismatch_count++;
					end
					if (rsp.payload.status !== oldest.status) begin
						$error("status: expected %0d, got %0d",
							oldest.status, rsp.payload.status);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready)
				owed_replies.push_back(predict_region_reply(req.payload));
		end
		replies_owed = owed_replies.size();
	end

endmodule

### dv/first_fit_region_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// allocate and free words under a series of window settings, bursty sender
// and stalling receiver; the checker predicts replies, this top gives verdict
// ----------------------------------------------------------------------------
module first_fit_region_allocator_tb;
	import ffra_pkg::*;

	localparam int MAX_REGIONS = 32;
	localparam int PAGE_BYTES  = 4096;
	localparam logic [ADDR_W-1:0]    ALL_ONES48    = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // no register behind it
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned LIVE_KEEP   = 48;

	// receiver pacing styles
	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PULSED} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	int unsigned          mismatch_count;
	int unsigned          replies_owed;

	// stimulus-side bookkeeping
	logic [ADDR_W-1:0] live_starts [$];   // starts handed out, candidates for free
	logic [ADDR_W-1:0] cur_base = '0;
	int unsigned       cur_gap_max = 0;
	int unsigned       burst_left = 0;
	bit                rsp_hold_req = 1'b0;

	ffra_in_if  req_ch ();
	ffra_out_if rsp_ch ();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	first_fit_region_allocator #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	first_fit_region_allocator_checker #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.replies_owed   (replies_owed)
	);

	// remember granted starts so that most frees hit a real region
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && rsp_ch.payload.status == ST_OK
				&& rsp_ch.payload.region_address != '0) begin
			live_starts.push_back(rsp_ch.payload.region_address);
			if (live_starts.size() > LIVE_KEEP) void'(live_starts.pop_front());
		end
	end

	function automatic logic [ADDR_W-1:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	// the field a word does not use still gets random bits
	function automatic in_word_t alloc_word(logic [REQ_W-1:0] bytes);
		in_word_t w;
		w.kind          = KIND_ALLOC;
		w.request_bytes = bytes;
		w.free_address  = rand48();
		return w;
	endfunction

	function automatic in_word_t free_word(logic [ADDR_W-1:0] addr);
		in_word_t w;
		w.kind          = KIND_FREE;
		w.request_bytes = $urandom;
		w.free_address  = addr;
		return w;
	endfunction

	// mostly sane sizes and frees of live regions, plus every kind of reject
	function automatic in_word_t random_word(int unsigned alloc_pct);
		int unsigned       pick;
		int unsigned       slot;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			if (pick < 3)  return alloc_word('0);
			if (pick < 7)  return alloc_word($urandom);
			if (pick < 9)  return alloc_word('1);
			if (pick < 20) return alloc_word(REQ_W'(PAGE_BYTES * $urandom_range(1, 8)));
			if (pick < 30) return alloc_word($urandom_range(1, 32'h0100_0000));
			return alloc_word($urandom_range(1, 6 * PAGE_BYTES));
		end
		if (pick < 60 && live_starts.size() > 0) begin
			slot = $urandom_range(0, live_starts.size() - 1);
			a    = live_starts[slot];
			live_starts.delete(slot);
			return free_word(a);
		end
		if (pick < 68) return free_word('0);
		if (pick < 78) begin
			// just off a page boundary
			a = (live_starts.size() > 0) ? live_starts[0] : cur_base;
			return free_word(a | ADDR_W'($urandom_range(1, PAGE_BYTES - 1)));
		end
		if (pick < 90)
			return free_word(cur_base + ADDR_W'(PAGE_BYTES * $urandom_range(0, 64)));
		return free_word(rand48());
	endfunction

	// one word per call; decides the idle gap that follows it
	task automatic send_item(in_word_t w);
		req_ch.payload <= w;
		req_ch.valid   <= 1'b1;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		@(negedge clk);
		if ($urandom_range(0, 199) == 0) begin
			// sender waits for every reply before going on
			req_ch.valid <= 1'b0;
			wait (replies_owed == 0);
			@(negedge clk);
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (cur_gap_max > 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, cur_gap_max)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// block is idle once the last owed reply has been taken
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		wait (replies_owed == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// new window settings over whatever table is left from the last phase
	task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] wend,
			logic [ADDR_W-1:0] limit, int unsigned n_items, int unsigned alloc_pct,
			int unsigned gap_max, bit hold_rsp);
		write_reg(CFG_WINDOW_BASE, base);
		write_reg(CFG_WINDOW_END, wend);
		write_reg(CFG_MAX_REQUEST, limit);
		cur_base    = base;
		cur_gap_max = gap_max;
		if (hold_rsp) rsp_hold_req = 1'b1;
		repeat (n_items) send_item(random_word(alloc_pct));
		drain_replies();
	endtask

	// receiver: changes its pacing now and then, and holds off on request
	initial begin : sink_pacing
		ready_mode_t mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned beat;
		mode      = RDY_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		beat      = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// long stall, the block fills and stops taking words
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = ready_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				beat++;
				case (mode)
					RDY_ALWAYS: rsp_ch.ready <= 1'b1;
					RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default:    rsp_ch.ready <= (beat % 7 < 3);
				endcase
			end
		end
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("first_fit_region_allocator_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] rbase;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words under the reset window
		cur_gap_max = 3;
		send_item(alloc_word('0));                       // zero size
		send_item(alloc_word(32'd1));                    // one page at the base
		send_item(alloc_word(REQ_W'(PAGE_BYTES)));       // exact page
		send_item(alloc_word(REQ_W'(PAGE_BYTES + 1)));   // rounds up to two pages
		send_item(alloc_word('1));                       // rounds to 4 GiB, oversize
		send_item(alloc_word(32'h4000_0001));            // just over the size limit
		send_item(alloc_word(32'h4000_0000));            // at the limit, no room
		send_item(alloc_word(32'h3FFF_FFFF));            // rounds to the limit, no room
		send_item(free_word('0));                        // null address
		send_item(free_word(ADDR_W'(PAGE_BYTES / 2 + 1)));
		send_item(free_word(ALL_ONES48));                // all ones, misaligned
		send_item(free_word(ALL_ONES48 & ~ADDR_W'(PAGE_BYTES - 1)));  // not found
		send_item(free_word(ADDR_W'(2 * PAGE_BYTES)));   // second region
		send_item(alloc_word(REQ_W'(PAGE_BYTES)));       // first fit into that hole
		send_item(alloc_word(REQ_W'(PAGE_BYTES)));       // gap ending at a start is too small
		send_item(free_word(ADDR_W'(4 * PAGE_BYTES)));
		send_item(free_word(ADDR_W'(4 * PAGE_BYTES)));   // already gone
		drain_replies();

		// reset window again, heavy on allocates so the table fills up
		run_phase('0, WINDOW_END_RST, MAX_REQUEST_RST, 300, 70, 10, 1'b0);
		// tight window, receiver holds off
		run_phase(48'h1_0000, 48'h1_0000 + ADDR_W'(48 * PAGE_BYTES),
			ADDR_W'(8 * PAGE_BYTES), 250, 50, 6, 1'b1);
		// widest settings, back to back words
		run_phase('0, ALL_ONES48, ALL_ONES48, 250, 55, 0, 1'b0);
		// window at the very top of the address space
		run_phase(ALL_ONES48 - ADDR_W'(64 * PAGE_BYTES) + 1, ALL_ONES48,
			ADDR_W'(16 * PAGE_BYTES), 200, 45, 12, 1'b0);
		// random page aligned window
		rbase = rand48() & ~ADDR_W'(PAGE_BYTES - 1);
		rbase[ADDR_W-1:40] = '0;
		run_phase(rbase, rbase + ADDR_W'(PAGE_BYTES * $urandom_range(16, 2000)),
			ADDR_W'(PAGE_BYTES * $urandom_range(1, 64)), 250, 60, 8, 1'b1);
		// base off a page boundary, so granted starts are misaligned
		rbase = 48'h10_0000 + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
		run_phase(rbase, rbase + ADDR_W'(200 * PAGE_BYTES), 48'h1_0000, 250, 50, 5, 1'b0);
		// unused register index, then everything at zero
		write_reg(CFG_SPARE_IDX, rand48());
		run_phase('0, '0, '0, 60, 60, 3, 1'b0);
		// fully random register values
		run_phase(rand48(), rand48(), rand48(), 150, 50, 8, 1'b0);
		// reset window again, mostly frees to empty the table
		run_phase('0, WINDOW_END_RST, MAX_REQUEST_RST, 270, 35, 10, 1'b0);

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && replies_owed == 0)
			$display("first_fit_region_allocator_tb: done, clean");
		else
			$display("first_fit_region_allocator_tb: done, errors");
		$finish;
	end

endmodule
